/* design/pvcf_pkg.sv */
// Shared types, codes and saturation helpers for the position/velocity filter.
`default_nettype none

package pvcf_pkg;

    // Field and datapath widths
    localparam int POS_W  = 16;
    localparam int ACC_W  = 24;
    localparam int ST_W   = 40;
    localparam int FP_W   = 32;
    localparam int CEIL_W = 15;
    localparam int OPND_W = 41;
    localparam int RES_W  = 42;
    localparam int WIDE_W = 48;

    // Item kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_TICK5  = 2'd1;
    localparam logic [1:0] KIND_TICK2  = 2'd2;

    // Axis indexes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Register index bit of paddr
    localparam logic REG_Z_CEIL = 1'b0;

    // Saturation bounds
    localparam logic signed [WIDE_W-1:0] S40_MAX = 48'sh00_7F_FFFF_FFFF;
    localparam logic signed [WIDE_W-1:0] S40_MIN = 48'shFF_80_0000_0000;
    localparam logic signed [ST_W-1:0]   S32_MAX = 40'sh00_7FFF_FFFF;
    localparam logic signed [ST_W-1:0]   S32_MIN = 40'shFF_8000_0000;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_ISSUE,
        CS_WAIT,
        CS_WB,
        CS_DONE
    } core_state_t;

    typedef enum logic [2:0] {
        OP_LP_POS,
        OP_LP_ACC,
        OP_PRED,
        OP_INT,
        OP_WGT,
        OP_TGT,
        OP_BLEND
    } op_t;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_RND
    } mul_phase_t;

    typedef struct packed {
        logic idle;
        logic load;
    } core_stat_t;

    function automatic logic signed [ST_W-1:0] sat40(input logic signed [WIDE_W-1:0] x);
        logic signed [ST_W-1:0] r;
        if (x > S40_MAX) begin
            r = S40_MAX[ST_W-1:0];
        end else if (x < S40_MIN) begin
            r = S40_MIN[ST_W-1:0];
        end else begin
            r = x[ST_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [FP_W-1:0] sat32(input logic signed [ST_W-1:0] x);
        logic signed [FP_W-1:0] r;
        if (x > S32_MAX) begin
            r = S32_MAX[FP_W-1:0];
        end else if (x < S32_MIN) begin
            r = S32_MIN[FP_W-1:0];
        end else begin
            r = x[FP_W-1:0];
        end
        return r;
    endfunction

    // Sign extension to the wide sum width
    function automatic logic signed [WIDE_W-1:0] wext40(input logic signed [ST_W-1:0] x);
        return {{(WIDE_W-ST_W){x[ST_W-1]}}, x};
    endfunction

    function automatic logic signed [WIDE_W-1:0] wext42(input logic signed [RES_W-1:0] x);
        return {{(WIDE_W-RES_W){x[RES_W-1]}}, x};
    endfunction

endpackage

`default_nettype wire

/* design/pvcf_mulq.sv */
// Shared fixed-point multiplier: two partial products, then round half away from zero.
`default_nettype none

module pvcf_mulq #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [pvcf_pkg::OPND_W-1:0]    a,
    input  wire logic [FRAC_BITS:0]                    c,
    output logic                                       done,
    output logic signed [pvcf_pkg::RES_W-1:0]          res
);
    import pvcf_pkg::*;

    localparam int CW   = FRAC_BITS + 1;
    localparam int LO_W = 21;
    localparam int HI_W = OPND_W - LO_W;
    localparam int PW   = OPND_W + CW;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

    mul_phase_t phase_reg, phase_next;
    logic [OPND_W-1:0]      mag_reg;
    logic                   neg_reg;
    logic [CW-1:0]          c_reg;
    logic [PW-1:0]          acc_reg;
    logic signed [RES_W-1:0] res_reg;
    logic                   done_reg;

    logic [LO_W+CW-1:0] lo_prod;
    logic [HI_W+CW-1:0] hi_prod;
    logic [PW:0]        rnd_sum;
    logic [OPND_W-1:0]  p_mag;

    // partial products and rounding
    assign lo_prod = mag_reg[LO_W-1:0] * c_reg;
    assign hi_prod = mag_reg[OPND_W-1:LO_W] * c_reg;
    assign rnd_sum = {1'b0, acc_reg} + HALF;
    assign p_mag   = rnd_sum[FRAC_BITS +: OPND_W];

    // phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == MP_RND);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            MP_IDLE: if (start) phase_next = MP_LO;
            MP_LO:   phase_next = MP_HI;
            MP_HI:   phase_next = MP_RND;
            MP_RND:  phase_next = MP_IDLE;
            default: phase_next = MP_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (phase_reg)
            MP_IDLE: begin
                if (start) begin
                    mag_reg <= a[OPND_W-1] ? OPND_W'(-a) : OPND_W'(a);
                    neg_reg <= a[OPND_W-1];
                    c_reg   <= c;
                end
            end
            MP_LO: acc_reg <= PW'(lo_prod);
            MP_HI: acc_reg <= acc_reg + (PW'(hi_prod) << LO_W);
            MP_RND: begin
                if (neg_reg) begin
                    res_reg <= -$signed({1'b0, p_mag});
                end else begin
                    res_reg <= $signed({1'b0, p_mag});
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

/* design/pvcf_core.sv */
// Sequencer and filter state: runs the filter steps through the shared multiplier.
`default_nettype none

module pvcf_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic [1:0]                           kind,
    input  wire logic signed [pvcf_pkg::POS_W-1:0]    pos_x,
    input  wire logic signed [pvcf_pkg::POS_W-1:0]    pos_y,
    input  wire logic signed [pvcf_pkg::POS_W-1:0]    pos_z,
    input  wire logic signed [pvcf_pkg::ACC_W-1:0]    acc_x,
    input  wire logic signed [pvcf_pkg::ACC_W-1:0]    acc_y,
    input  wire logic signed [pvcf_pkg::ACC_W-1:0]    acc_z,
    input  wire logic [pvcf_pkg::CEIL_W-1:0]          z_ceil,
    input  wire logic                                 out_free,
    output pvcf_pkg::core_stat_t                      stat,
    output logic signed [pvcf_pkg::ST_W-1:0]          speed_x,
    output logic signed [pvcf_pkg::ST_W-1:0]          speed_y,
    output logic signed [pvcf_pkg::ST_W-1:0]          speed_z,
    output logic signed [pvcf_pkg::FP_W-1:0]          filt_x,
    output logic signed [pvcf_pkg::FP_W-1:0]          filt_y,
    output logic signed [pvcf_pkg::FP_W-1:0]          filt_z
);
    import pvcf_pkg::*;

    localparam int CW = FRAC_BITS + 1;
    // gains rounded to nearest in the fixed-point format
    localparam longint K_LP5_L    = ((longint'(471)  << FRAC_BITS) + 5000)  / 10000;
    localparam longint K_PRD_XY_L = ((longint'(1256) << FRAC_BITS) + 50000) / 100000;
    localparam longint K_PRD_Z_L  = ((longint'(1884) << FRAC_BITS) + 50000) / 100000;
    localparam longint K_INT_L    = ((longint'(1884) << FRAC_BITS) + 50000) / 100000;
    localparam longint K_BL_XY_L  = ((longint'(2512) << FRAC_BITS) + 50000) / 100000;
    localparam longint K_BL_Z_L   = ((longint'(1256) << FRAC_BITS) + 50000) / 100000;
    localparam longint K_W_MIN_L  = ((longint'(1)    << FRAC_BITS) + 50)    / 100;
    localparam logic [CW-1:0] K_LP5    = CW'(K_LP5_L);
    localparam logic [CW-1:0] K_PRD_XY = CW'(K_PRD_XY_L);
    localparam logic [CW-1:0] K_PRD_Z  = CW'(K_PRD_Z_L);
    localparam logic [CW-1:0] K_INT    = CW'(K_INT_L);
    localparam logic [CW-1:0] K_BL_XY  = CW'(K_BL_XY_L);
    localparam logic [CW-1:0] K_BL_Z   = CW'(K_BL_Z_L);
    localparam logic [CW-1:0] K_W_MIN  = CW'(K_W_MIN_L);
    localparam logic [CW-1:0] K_W_MAX  = CW'(1) << FRAC_BITS;

    core_state_t state_reg, state_next;
    op_t         op_reg, op_next;
    logic [1:0]  axis_reg, axis_next;
    logic        seq_end;

    logic signed [POS_W-1:0] rp_reg [3];
    logic signed [ACC_W-1:0] ra_reg [3];
    logic signed [ST_W-1:0]  fp_reg [3];
    logic signed [ST_W-1:0]  fa_reg [3];
    logic signed [ST_W-1:0]  pp_reg [3];
    logic signed [ST_W-1:0]  se_reg [3];
    logic signed [ST_W-1:0]  s_reg;
    logic signed [ST_W-1:0]  tgt_reg;
    logic [CW-1:0]           w_reg;

    logic signed [POS_W-1:0]  rp_a;
    logic signed [ACC_W-1:0]  ra_a;
    logic signed [ST_W-1:0]   fp_a, fa_a, pp_a, se_a;
    logic signed [OPND_W-1:0] p_sc, a_sc, d;
    logic signed [WIDE_W-1:0] dx, d38, d14;
    logic signed [OPND_W-1:0] opnd;
    logic [CW-1:0]            cval;
    logic                     mul_done;
    logic signed [RES_W-1:0]  mul_res;
    logic [RES_W-1:0]         r_abs;
    logic [CW-1:0]            w_new;
    logic signed [POS_W-1:0]  z_clamped;

    // current axis operands
    assign rp_a = rp_reg[axis_reg];
    assign ra_a = ra_reg[axis_reg];
    assign fp_a = fp_reg[axis_reg];
    assign fa_a = fa_reg[axis_reg];
    assign pp_a = pp_reg[axis_reg];
    assign se_a = se_reg[axis_reg];

    // raw values scaled into the filter format
    assign p_sc = {{(OPND_W-POS_W-FRAC_BITS){rp_a[POS_W-1]}}, rp_a, {FRAC_BITS{1'b0}}};
    assign a_sc = {{(OPND_W-ACC_W-FRAC_BITS+8){ra_a[ACC_W-1]}}, ra_a, {(FRAC_BITS-8){1'b0}}};

    // velocity cue and its gains by shift and add
    assign d   = {fp_a[ST_W-1], fp_a} - {pp_a[ST_W-1], pp_a};
    assign dx  = {{(WIDE_W-OPND_W){d[OPND_W-1]}}, d};
    assign d38 = (dx <<< 5) + (dx <<< 2) + (dx <<< 1);
    assign d14 = (dx <<< 4) - (dx <<< 1);

    // multiplier operand and gain selection
    always_comb begin
        opnd = '0;
        cval = K_LP5;
        unique case (op_reg)
            OP_LP_POS: begin
                opnd = p_sc - {fp_a[ST_W-1], fp_a};
                cval = K_LP5;
            end
            OP_LP_ACC: begin
                opnd = a_sc - {fa_a[ST_W-1], fa_a};
                cval = K_LP5;
            end
            OP_PRED: begin
                opnd = {fp_a[ST_W-1], fp_a} - {pp_a[ST_W-1], pp_a};
                cval = (axis_reg == AXIS_Z) ? K_PRD_Z : K_PRD_XY;
            end
            OP_INT: begin
                opnd = {fa_a[ST_W-1], fa_a};
                cval = K_INT;
            end
            OP_WGT: begin
                opnd = {fa_a[ST_W-1], fa_a};
                cval = K_W_MIN;
            end
            OP_TGT: begin
                opnd = OPND_W'(sat40(d38));
                cval = w_reg;
            end
            OP_BLEND: begin
                opnd = {tgt_reg[ST_W-1], tgt_reg} - {s_reg[ST_W-1], s_reg};
                cval = (axis_reg == AXIS_Z) ? K_BL_Z : K_BL_XY;
            end
            default: ;
        endcase
    end

    pvcf_mulq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mulq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == CS_ISSUE),
        .a       (opnd),
        .c       (cval),
        .done    (mul_done),
        .res     (mul_res)
    );

    // blend weight clamped to 0.01..1
    assign r_abs = mul_res[RES_W-1] ? RES_W'(-mul_res) : RES_W'(mul_res);
    always_comb begin
        if (r_abs < RES_W'(K_W_MIN)) begin
            w_new = K_W_MIN;
        end else if (r_abs > RES_W'(K_W_MAX)) begin
            w_new = K_W_MAX;
        end else begin
            w_new = r_abs[CW-1:0];
        end
    end

    // Z sample clamp
    always_comb begin
        if (pos_z < 0) begin
            z_clamped = '0;
        end else if (pos_z > $signed({1'b0, z_ceil})) begin
            z_clamped = $signed({1'b0, z_ceil});
        end else begin
            z_clamped = pos_z;
        end
    end

    // step order
    always_comb begin
        op_next   = op_reg;
        axis_next = axis_reg;
        seq_end   = 1'b0;
        unique case (op_reg)
            OP_LP_POS: op_next = OP_LP_ACC;
            OP_LP_ACC: begin
                op_next   = OP_LP_POS;
                axis_next = axis_reg + 2'd1;
                seq_end   = (axis_reg == AXIS_Z);
            end
            OP_PRED:   op_next = OP_INT;
            OP_INT:    op_next = (axis_reg == AXIS_Z) ? OP_BLEND : OP_WGT;
            OP_WGT:    op_next = OP_TGT;
            OP_TGT:    op_next = OP_BLEND;
            OP_BLEND: begin
                op_next   = OP_PRED;
                axis_next = axis_reg + 2'd1;
                seq_end   = (axis_reg == AXIS_Z);
            end
            default:   op_next = OP_LP_POS;
        endcase
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            op_reg    <= OP_LP_POS;
            axis_reg  <= AXIS_X;
        end else begin
            state_reg <= state_next;
            if (state_reg == CS_IDLE && start) begin
                op_reg   <= (kind == KIND_TICK5) ? OP_LP_POS : OP_PRED;
                axis_reg <= AXIS_X;
            end else if (state_reg == CS_WB) begin
                op_reg   <= op_next;
                axis_reg <= axis_next;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    if (kind == KIND_TICK5 || kind == KIND_TICK2) begin
                        state_next = CS_ISSUE;
                    end else begin
                        state_next = CS_DONE;
                    end
                end
            end
            CS_ISSUE: state_next = CS_WAIT;
            CS_WAIT:  if (mul_done) state_next = CS_WB;
            CS_WB:    state_next = seq_end ? CS_DONE : CS_ISSUE;
            CS_DONE:  if (out_free) state_next = CS_IDLE;
            default:  state_next = CS_IDLE;
        endcase
    end

    // filter state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                rp_reg[i] <= '0;
                ra_reg[i] <= '0;
                fp_reg[i] <= '0;
                fa_reg[i] <= '0;
                pp_reg[i] <= '0;
                se_reg[i] <= '0;
            end
        end else begin
            if (state_reg == CS_IDLE && start && kind == KIND_SAMPLE) begin
                rp_reg[0] <= pos_x;
                rp_reg[1] <= pos_y;
                rp_reg[2] <= z_clamped;
                ra_reg[0] <= acc_x;
                ra_reg[1] <= acc_y;
                ra_reg[2] <= acc_z;
            end
            if (state_reg == CS_WB) begin
                case (op_reg)
                    OP_LP_POS: fp_reg[axis_reg] <= sat40(wext40(fp_a) + wext42(mul_res));
                    OP_LP_ACC: fa_reg[axis_reg] <= sat40(wext40(fa_a) + wext42(mul_res));
                    OP_PRED:   pp_reg[axis_reg] <= sat40(wext40(pp_a) + wext42(mul_res));
                    OP_BLEND:  se_reg[axis_reg] <= sat40(wext40(s_reg) + wext42(mul_res));
                    default: ;
                endcase
            end
        end
    end

    // per-axis scratch
    always_ff @(posedge aclk) begin
        if (state_reg == CS_WB) begin
            case (op_reg)
                OP_INT: begin
                    s_reg <= sat40(wext40(se_a) + wext42(mul_res));
                    if (axis_reg == AXIS_Z) begin
                        tgt_reg <= sat40(d14);
                    end
                end
                OP_WGT: w_reg   <= w_new;
                OP_TGT: tgt_reg <= mul_res[ST_W-1:0];
                default: ;
            endcase
        end
    end

    assign stat.idle = (state_reg == CS_IDLE);
    assign stat.load = (state_reg == CS_DONE) && out_free;

    assign speed_x = se_reg[0];
    assign speed_y = se_reg[1];
    assign speed_z = se_reg[2];
    assign filt_x  = sat32(fp_reg[0]);
    assign filt_y  = sat32(fp_reg[1]);
    assign filt_z  = sat32(fp_reg[2]);

endmodule

`default_nettype wire

/* design/position_velocity_complementary_filter_unit.sv */
// Top level: register port, input/output words and the filter core.
//
//  channel | ports          | carries
//  --------+----------------+-----------------------------------------------
//  input   | s_valid/s_ready| kind, raw XYZ position, raw XYZ acceleration
//  output  | m_valid/m_ready| XYZ speed, low-passed XYZ position
//  config  | APB psel...    | z_pos_ceiling at byte address 0
//
// A sample or an unknown kind runs no multiplier step. A 5 ms tick runs six
// multiplier steps, a 2 ms tick thirteen; each step goes through issue, two partial
// products, round, result handoff and write back on the one shared multiplier.
// s_ready is high only while the sequencer is idle; a finished word waits in the output
// register and the next word is accepted meanwhile. Reset is synchronous, active low,
// and clears all filter state; the ceiling returns to 1500.
`default_nettype none

module position_velocity_complementary_filter_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    // input words
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_kind,
    input  wire logic signed [pvcf_pkg::POS_W-1:0]   s_pos_x,
    input  wire logic signed [pvcf_pkg::POS_W-1:0]   s_pos_y,
    input  wire logic signed [pvcf_pkg::POS_W-1:0]   s_pos_z,
    input  wire logic signed [pvcf_pkg::ACC_W-1:0]   s_acc_x,
    input  wire logic signed [pvcf_pkg::ACC_W-1:0]   s_acc_y,
    input  wire logic signed [pvcf_pkg::ACC_W-1:0]   s_acc_z,
    // result words
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [pvcf_pkg::ST_W-1:0]         m_speed_x,
    output logic signed [pvcf_pkg::ST_W-1:0]         m_speed_y,
    output logic signed [pvcf_pkg::ST_W-1:0]         m_speed_z,
    output logic signed [pvcf_pkg::FP_W-1:0]         m_filt_pos_x,
    output logic signed [pvcf_pkg::FP_W-1:0]         m_filt_pos_y,
    output logic signed [pvcf_pkg::FP_W-1:0]         m_filt_pos_z
);
    import pvcf_pkg::*;

    localparam logic [CEIL_W-1:0] CEIL_RESET = 15'd1500;

    logic [CEIL_W-1:0] ceil_reg;
    logic              m_valid_reg;
    logic              out_free;
    core_stat_t        stat;

    logic signed [ST_W-1:0] spd_x, spd_y, spd_z;
    logic signed [FP_W-1:0] flt_x, flt_y, flt_z;
    logic signed [ST_W-1:0] speed_x_reg, speed_y_reg, speed_z_reg;
    logic signed [FP_W-1:0] filt_x_reg, filt_y_reg, filt_z_reg;

    // register port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceil_reg <= CEIL_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_Z_CEIL) begin
            ceil_reg <= pwdata[CEIL_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_Z_CEIL) ? {17'd0, ceil_reg} : 32'd0;

    assign s_ready  = stat.idle;
    assign out_free = !m_valid_reg || m_ready;

    pvcf_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid && s_ready),
        .kind     (s_kind),
        .pos_x    (s_pos_x),
        .pos_y    (s_pos_y),
        .pos_z    (s_pos_z),
        .acc_x    (s_acc_x),
        .acc_y    (s_acc_y),
        .acc_z    (s_acc_z),
        .z_ceil   (ceil_reg),
        .out_free (out_free),
        .stat     (stat),
        .speed_x  (spd_x),
        .speed_y  (spd_y),
        .speed_z  (spd_z),
        .filt_x   (flt_x),
        .filt_y   (flt_y),
        .filt_z   (flt_z)
    );

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.load) begin
            speed_x_reg <= spd_x;
            speed_y_reg <= spd_y;
            speed_z_reg <= spd_z;
            filt_x_reg  <= flt_x;
            filt_y_reg  <= flt_y;
            filt_z_reg  <= flt_z;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_speed_x    = speed_x_reg;
    assign m_speed_y    = speed_y_reg;
    assign m_speed_z    = speed_z_reg;
    assign m_filt_pos_x = filt_x_reg;
    assign m_filt_pos_y = filt_y_reg;
    assign m_filt_pos_z = filt_z_reg;

endmodule

`default_nettype wire

/* design/pvcf_checker.sv */
// Port-level checks for the filter unit, bound to the top level.
`default_nettype none

module pvcf_port_checks (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [39:0] m_speed_x,
    input wire logic [31:0] m_filt_pos_x
);

    // an accepted word keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted word");

    // a result appears only after the sequencer was busy
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result word without a busy period");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_speed_x) && $stable(m_filt_pos_x))
        else $error("stalled result word changed");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind position_velocity_complementary_filter_unit pvcf_port_checks u_pvcf_port_checks (.*);

`default_nettype wire
